// ===== rtl/core/ffme_pkg.sv =====
// Package for the Fourier field map evaluator: types, codes, constants
// and shared arithmetic helpers. No dependencies.
package ffme_pkg;

    localparam int MAX_HARMONICS = 16;
    localparam int COEF_DEPTH    = 31;
    localparam int COEF_W        = 32;
    localparam int COEF_AW       = $clog2(COEF_DEPTH);
    localparam int TABLE_HARM    = (COEF_DEPTH + 1) / 2;
    localparam int HARM_LIMIT    = (MAX_HARMONICS < TABLE_HARM) ? MAX_HARMONICS : TABLE_HARM;
    localparam int HARM_W        = 5;
    localparam int LOOP_W        = $clog2(TABLE_HARM);
    localparam int CORDIC_STEPS  = 30;
    localparam int CSTEP_W       = $clog2(CORDIC_STEPS);
    localparam int CW            = 34;
    localparam int K1_W          = 37;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [63:0]   MAX_S64     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]   OUT_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0]   OUT_MIN     = 64'shFFFF_8000_0000_0000;
    localparam logic [31:0]          HALF_TURN   = 32'h8000_0000;
    localparam logic [31:0]          QUARTER_TURN = 32'h4000_0000;

    localparam logic [5:0] SH_NONE = 6'd0;
    localparam logic [5:0] SH_HALF = 6'd1;
    localparam logic [5:0] SH_Q16  = 6'd16;
    localparam logic [5:0] SH_POS  = 6'd20;
    localparam logic [5:0] SH_R2   = 6'd42;
    localparam logic [5:0] SH_R3   = 6'd44;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_HARMONICS   = 2'd0,
        REG_PHASE_SCALE = 2'd1,
        REG_K_BASE      = 2'd2
    } t_reg;

    typedef enum logic [4:0] {
        MOP_ZP, MOP_XX, MOP_YY,
        MOP_AC, MOP_BS, MOP_AS, MOP_BC,
        MOP_K2, MOP_K3,
        MOP_T1K1, MOP_T0K2, MOP_T1K3,
        MOP_HALF, MOP_E3R, MOP_E2R, MOP_EX, MOP_EY
    } t_mop;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MSTART, ST_MWAIT, ST_RD0, ST_LD0,
        ST_RDA, ST_RDB, ST_CINIT, ST_CSTEP, ST_CEND, ST_DONE
    } t_state;

    typedef struct packed {
        logic               load_we;
        logic               lat_in;
        logic [COEF_AW-1:0] rd_addr;
        logic               ld_ez;
        logic               harm_adv;
        logic               ld_a;
        logic               ld_b;
        logic               c_init;
        logic               c_step;
        logic [CSTEP_W-1:0] c_idx;
        logic               c_end;
        logic               mul_start;
        t_mop               mop;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
    } t_stat;

    function automatic logic [31:0] atan_turn(input logic [CSTEP_W-1:0] i);
        case (i)
            5'd0:  return 32'h20000000;
            5'd1:  return 32'h12E4051E;
            5'd2:  return 32'h09FB385B;
            5'd3:  return 32'h051111D4;
            5'd4:  return 32'h028B0D43;
            5'd5:  return 32'h0145D7E1;
            5'd6:  return 32'h00A2F61E;
            5'd7:  return 32'h00517C55;
            5'd8:  return 32'h0028BE53;
            5'd9:  return 32'h00145F2F;
            5'd10: return 32'h000A2F98;
            5'd11: return 32'h000517CC;
            5'd12: return 32'h00028BE6;
            5'd13: return 32'h000145F3;
            5'd14: return 32'h0000A2F9;
            5'd15: return 32'h0000517C;
            5'd16: return 32'h000028BE;
            5'd17: return 32'h0000145F;
            5'd18: return 32'h00000A2F;
            5'd19: return 32'h00000517;
            5'd20: return 32'h0000028B;
            5'd21: return 32'h00000145;
            5'd22: return 32'h000000A2;
            5'd23: return 32'h00000051;
            5'd24: return 32'h00000028;
            5'd25: return 32'h00000014;
            5'd26: return 32'h0000000A;
            5'd27: return 32'h00000005;
            5'd28: return 32'h00000002;
            5'd29: return 32'h00000001;
            default: return 32'h00000000;
        endcase
    endfunction

    function automatic logic signed [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(MAX_S64))
            return MAX_S64;
        else if (s < -65'(MAX_S64))
            return -MAX_S64;
        else
            return s[63:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > OUT_MAX)
            return OUT_MAX[47:0];
        else if (v < OUT_MIN)
            return OUT_MIN[47:0];
        else
            return v[47:0];
    endfunction

endpackage

// ===== rtl/core/ffme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/ffme_mul.sv =====
// Sequential 64x64 magnitude multiplier on one 32x32 multiplier, with
// shift, saturation to 63 bits and sign. Depends on ffme_pkg.
module ffme_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_am,
    input  logic [63:0]        i_bm,
    input  logic               i_neg,
    input  logic [5:0]         i_sh,
    output logic               o_done,
    output logic signed [63:0] o_prod
);

    localparam logic [63:0] MAX_S64_U = ffme_pkg::MAX_S64;

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic [63:0]  r_am;
    logic [63:0]  r_bm;
    logic         r_neg;
    logic [5:0]   r_sh;
    logic [63:0]  r_pp;
    logic [1:0]   r_pw;
    logic [127:0] r_acc;
    logic         r_done;
    logic signed [63:0] r_res;

    logic [31:0]  ah;
    logic [31:0]  bh;
    logic [63:0]  pp_c;
    logic [127:0] wide;
    logic [63:0]  mag_c;

    always_comb begin
        ah    = r_cnt[1] ? r_am[63:32] : r_am[31:0];
        bh    = r_cnt[0] ? r_bm[63:32] : r_bm[31:0];
        pp_c  = 64'(ah) * 64'(bh);
        wide  = r_acc >> r_sh;
        mag_c = (|wide[127:63]) ? 64'(MAX_S64_U) : {1'b0, wide[62:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_am  <= i_am;
            r_bm  <= i_bm;
            r_neg <= i_neg;
            r_sh  <= i_sh;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= 3'd3) begin
                r_pp <= pp_c;
                r_pw <= 2'(r_cnt[0]) + 2'(r_cnt[1]);
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + ({64'b0, r_pp} << {r_pw, 5'b0});
            end
            if (r_cnt == 3'd5) begin
                r_res <= r_neg ? -$signed(mag_c) : $signed(mag_c);
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_res;

endmodule

// ===== rtl/core/ffme_ctrl.sv =====
// Controller of the field map evaluator: sequences table reads, CORDIC
// steps and multiplies. Depends on ffme_pkg.
module ffme_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_operation,
    input  logic [ffme_pkg::HARM_W-1:0] i_harmonics,
    input  ffme_pkg::t_stat             i_stat,
    output ffme_pkg::t_cmd              o_cmd,
    output logic                        o_busy,
    output logic                        o_valid
);

    ffme_pkg::t_state r_state, n_state;
    ffme_pkg::t_mop   r_mop, n_mop;
    logic [ffme_pkg::LOOP_W-1:0]  r_l, n_l;
    logic [ffme_pkg::CSTEP_W-1:0] r_cnt, n_cnt;
    logic [ffme_pkg::HARM_W-1:0]  h_eff;
    logic                         more;

    always_comb begin
        if (i_harmonics == '0)
            h_eff = ffme_pkg::HARM_W'(1);
        else if (i_harmonics > ffme_pkg::HARM_W'(ffme_pkg::HARM_LIMIT))
            h_eff = ffme_pkg::HARM_W'(ffme_pkg::HARM_LIMIT);
        else
            h_eff = i_harmonics;
        more = (ffme_pkg::HARM_W'(r_l) + ffme_pkg::HARM_W'(1)) < h_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffme_pkg::ST_IDLE;
            r_mop   <= ffme_pkg::MOP_ZP;
            r_l     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_mop   <= n_mop;
            r_l     <= n_l;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mop   = r_mop;
        n_l     = r_l;
        n_cnt   = r_cnt;
        unique case (r_state)
            ffme_pkg::ST_IDLE: begin
                if (i_start && i_operation == ffme_pkg::OP_EVAL) begin
                    n_state = ffme_pkg::ST_MSTART;
                    n_mop   = ffme_pkg::MOP_ZP;
                end
            end
            ffme_pkg::ST_MSTART: n_state = ffme_pkg::ST_MWAIT;
            ffme_pkg::ST_MWAIT: begin
                if (i_stat.mul_done) begin
                    n_state = ffme_pkg::ST_MSTART;
                    unique case (r_mop)
                        ffme_pkg::MOP_ZP:   n_mop = ffme_pkg::MOP_XX;
                        ffme_pkg::MOP_XX:   n_mop = ffme_pkg::MOP_YY;
                        ffme_pkg::MOP_YY:   n_state = ffme_pkg::ST_RD0;
                        ffme_pkg::MOP_AC:   n_mop = ffme_pkg::MOP_BS;
                        ffme_pkg::MOP_BS:   n_mop = ffme_pkg::MOP_AS;
                        ffme_pkg::MOP_AS:   n_mop = ffme_pkg::MOP_BC;
                        ffme_pkg::MOP_BC:   n_mop = ffme_pkg::MOP_K2;
                        ffme_pkg::MOP_K2:   n_mop = ffme_pkg::MOP_K3;
                        ffme_pkg::MOP_K3:   n_mop = ffme_pkg::MOP_T1K1;
                        ffme_pkg::MOP_T1K1: n_mop = ffme_pkg::MOP_T0K2;
                        ffme_pkg::MOP_T0K2: n_mop = ffme_pkg::MOP_T1K3;
                        ffme_pkg::MOP_T1K3: begin
                            n_l = r_l + ffme_pkg::LOOP_W'(1);
                            if (more)
                                n_state = ffme_pkg::ST_RDA;
                            else
                                n_mop = ffme_pkg::MOP_HALF;
                        end
                        ffme_pkg::MOP_HALF: n_mop = ffme_pkg::MOP_E3R;
                        ffme_pkg::MOP_E3R:  n_mop = ffme_pkg::MOP_E2R;
                        ffme_pkg::MOP_E2R:  n_mop = ffme_pkg::MOP_EX;
                        ffme_pkg::MOP_EX:   n_mop = ffme_pkg::MOP_EY;
                        ffme_pkg::MOP_EY:   n_state = ffme_pkg::ST_DONE;
                        default:            n_state = ffme_pkg::ST_DONE;
                    endcase
                end
            end
            ffme_pkg::ST_RD0: n_state = ffme_pkg::ST_LD0;
            ffme_pkg::ST_LD0: begin
                n_l = ffme_pkg::LOOP_W'(1);
                if (h_eff > ffme_pkg::HARM_W'(1)) begin
                    n_state = ffme_pkg::ST_RDA;
                end else begin
                    n_state = ffme_pkg::ST_MSTART;
                    n_mop   = ffme_pkg::MOP_HALF;
                end
            end
            ffme_pkg::ST_RDA:   n_state = ffme_pkg::ST_RDB;
            ffme_pkg::ST_RDB:   n_state = ffme_pkg::ST_CINIT;
            ffme_pkg::ST_CINIT: begin
                n_state = ffme_pkg::ST_CSTEP;
                n_cnt   = '0;
            end
            ffme_pkg::ST_CSTEP: begin
                if (r_cnt == ffme_pkg::CSTEP_W'(ffme_pkg::CORDIC_STEPS - 1))
                    n_state = ffme_pkg::ST_CEND;
                else
                    n_cnt = r_cnt + ffme_pkg::CSTEP_W'(1);
            end
            ffme_pkg::ST_CEND: begin
                n_state = ffme_pkg::ST_MSTART;
                n_mop   = ffme_pkg::MOP_AC;
            end
            ffme_pkg::ST_DONE: n_state = ffme_pkg::ST_IDLE;
            default:           n_state = ffme_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.mop       = r_mop;
        o_cmd.c_idx     = r_cnt;
        o_busy          = (r_state != ffme_pkg::ST_IDLE);
        o_valid         = 1'b0;
        unique case (r_state)
            ffme_pkg::ST_IDLE: begin
                o_cmd.load_we = i_start && i_operation == ffme_pkg::OP_LOAD;
                o_cmd.lat_in  = i_start && i_operation == ffme_pkg::OP_EVAL;
            end
            ffme_pkg::ST_MSTART: o_cmd.mul_start = 1'b1;
            ffme_pkg::ST_MWAIT:  ;
            ffme_pkg::ST_RD0:    o_cmd.rd_addr = '0;
            ffme_pkg::ST_LD0:    o_cmd.ld_ez = 1'b1;
            ffme_pkg::ST_RDA: begin
                o_cmd.rd_addr  = ffme_pkg::COEF_AW'({r_l, 1'b0}) - ffme_pkg::COEF_AW'(1);
                o_cmd.harm_adv = 1'b1;
            end
            ffme_pkg::ST_RDB: begin
                o_cmd.rd_addr = ffme_pkg::COEF_AW'({r_l, 1'b0});
                o_cmd.ld_a    = 1'b1;
            end
            ffme_pkg::ST_CINIT: begin
                o_cmd.ld_b   = 1'b1;
                o_cmd.c_init = 1'b1;
            end
            ffme_pkg::ST_CSTEP:  o_cmd.c_step = 1'b1;
            ffme_pkg::ST_CEND:   o_cmd.c_end = 1'b1;
            ffme_pkg::ST_DONE:   o_valid = 1'b1;
            default:             ;
        endcase
    end

endmodule

// ===== rtl/core/ffme_dp.sv =====
// Datapath of the field map evaluator: coefficient RAM, CORDIC, shared
// multiplier and accumulators. Depends on ffme_pkg, ffme_ram, ffme_mul.
module ffme_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ffme_pkg::t_cmd               i_cmd,
    output ffme_pkg::t_stat              o_stat,
    input  logic [4:0]                   i_coef_index,
    input  logic signed [31:0]           i_coef_value,
    input  logic signed [31:0]           i_pos_x,
    input  logic signed [31:0]           i_pos_y,
    input  logic signed [31:0]           i_pos_z,
    input  logic [31:0]                  i_phase_scale,
    input  logic [31:0]                  i_k_base,
    output logic signed [47:0]           o_field_x,
    output logic signed [47:0]           o_field_y,
    output logic signed [47:0]           o_field_z
);

    localparam int CW = ffme_pkg::CW;

    logic [ffme_pkg::COEF_W-1:0] rdata;
    logic                        we;

    logic signed [31:0] r_x, r_y, r_z;
    logic [31:0]        r_base, r_phase;
    logic [63:0]        r_rr2;
    logic [ffme_pkg::K1_W-1:0] r_k1;
    logic [63:0]        r_k2, r_k3;
    logic signed [31:0] r_a, r_b, r_c, r_s;
    logic signed [63:0] r_p0, r_t0, r_t1;
    logic signed [63:0] r_ez, r_ezp, r_ezpp, r_ezppp, r_er;
    logic signed [47:0] r_fx, r_fy, r_fz;
    logic signed [CW-1:0] r_cx, r_cy, r_ca;
    logic               r_flip;

    logic [63:0]        m_am, m_bm;
    logic               m_neg;
    logic [5:0]         m_sh;
    logic               m_done;
    logic signed [63:0] prod;

    logic [31:0]          p_off, p_adj;
    logic                 p_flip;
    logic signed [CW-1:0] c_dx, c_dy, c_at, c_xf, c_yf, c_xc, c_yc;

    assign we = i_cmd.load_we && (i_coef_index < 5'(ffme_pkg::COEF_DEPTH));

    ffme_ram #(
        .WIDTH(ffme_pkg::COEF_W),
        .DEPTH(ffme_pkg::COEF_DEPTH)
    ) u_coef (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_coef_index),
        .i_wdata (i_coef_value),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        m_am  = '0;
        m_bm  = '0;
        m_neg = 1'b0;
        m_sh  = ffme_pkg::SH_NONE;
        unique case (i_cmd.mop)
            ffme_pkg::MOP_ZP: begin
                m_am = ffme_pkg::mag64(ffme_pkg::sext32(r_z));
                m_bm = {32'b0, i_phase_scale};
                m_neg = r_z[31];
            end
            ffme_pkg::MOP_XX: begin
                m_am = ffme_pkg::mag64(ffme_pkg::sext32(r_x));
                m_bm = m_am;
            end
            ffme_pkg::MOP_YY: begin
                m_am = ffme_pkg::mag64(ffme_pkg::sext32(r_y));
                m_bm = m_am;
            end
            ffme_pkg::MOP_AC: begin
                m_am = ffme_pkg::mag64(ffme_pkg::sext32(r_a));
                m_bm = ffme_pkg::mag64(ffme_pkg::sext32(r_c));
                m_neg = r_a[31] ^ r_c[31];
            end
            ffme_pkg::MOP_BS: begin
                m_am = ffme_pkg::mag64(ffme_pkg::sext32(r_b));
                m_bm = ffme_pkg::mag64(ffme_pkg::sext32(r_s));
                m_neg = r_b[31] ^ r_s[31];
            end
            ffme_pkg::MOP_AS: begin
                m_am = ffme_pkg::mag64(ffme_pkg::sext32(r_a));
                m_bm = ffme_pkg::mag64(ffme_pkg::sext32(r_s));
                m_neg = r_a[31] ^ r_s[31];
            end
            ffme_pkg::MOP_BC: begin
                m_am = ffme_pkg::mag64(ffme_pkg::sext32(r_b));
                m_bm = ffme_pkg::mag64(ffme_pkg::sext32(r_c));
                m_neg = r_b[31] ^ r_c[31];
            end
            ffme_pkg::MOP_K2: begin
                m_am = 64'(r_k1);
                m_bm = 64'(r_k1);
                m_sh = ffme_pkg::SH_Q16;
            end
            ffme_pkg::MOP_K3: begin
                m_am = r_k2;
                m_bm = 64'(r_k1);
                m_sh = ffme_pkg::SH_Q16;
            end
            ffme_pkg::MOP_T1K1: begin
                m_am = ffme_pkg::mag64(r_t1);
                m_bm = 64'(r_k1);
                m_neg = r_t1[63];
                m_sh = ffme_pkg::SH_Q16;
            end
            ffme_pkg::MOP_T0K2: begin
                m_am = ffme_pkg::mag64(r_t0);
                m_bm = r_k2;
                m_neg = r_t0[63];
                m_sh = ffme_pkg::SH_Q16;
            end
            ffme_pkg::MOP_T1K3: begin
                m_am = ffme_pkg::mag64(r_t1);
                m_bm = r_k3;
                m_neg = r_t1[63];
                m_sh = ffme_pkg::SH_Q16;
            end
            ffme_pkg::MOP_HALF: begin
                m_am = ffme_pkg::mag64(r_ezp);
                m_bm = 64'd1;
                m_neg = r_ezp[63];
                m_sh = ffme_pkg::SH_HALF;
            end
            ffme_pkg::MOP_E3R: begin
                m_am = ffme_pkg::mag64(r_ezppp);
                m_bm = r_rr2;
                m_neg = r_ezppp[63];
                m_sh = ffme_pkg::SH_R3;
            end
            ffme_pkg::MOP_E2R: begin
                m_am = ffme_pkg::mag64(r_ezpp);
                m_bm = r_rr2;
                m_neg = r_ezpp[63];
                m_sh = ffme_pkg::SH_R2;
            end
            ffme_pkg::MOP_EX: begin
                m_am = ffme_pkg::mag64(r_er);
                m_bm = ffme_pkg::mag64(ffme_pkg::sext32(r_x));
                m_neg = r_er[63] ^ r_x[31];
                m_sh = ffme_pkg::SH_POS;
            end
            ffme_pkg::MOP_EY: begin
                m_am = ffme_pkg::mag64(r_er);
                m_bm = ffme_pkg::mag64(ffme_pkg::sext32(r_y));
                m_neg = r_er[63] ^ r_y[31];
                m_sh = ffme_pkg::SH_POS;
            end
            default: ;
        endcase
    end

    ffme_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_am    (m_am),
        .i_bm    (m_bm),
        .i_neg   (m_neg),
        .i_sh    (m_sh),
        .o_done  (m_done),
        .o_prod  (prod)
    );

    assign o_stat.mul_done = m_done;

    always_comb begin
        p_off  = r_phase - ffme_pkg::QUARTER_TURN;
        p_flip = !p_off[31];
        p_adj  = p_flip ? r_phase - ffme_pkg::HALF_TURN : r_phase;
        c_dx   = r_cy >>> i_cmd.c_idx;
        c_dy   = r_cx >>> i_cmd.c_idx;
        c_at   = CW'(ffme_pkg::atan_turn(i_cmd.c_idx));
        c_xf   = r_flip ? -r_cx : r_cx;
        c_yf   = r_flip ? -r_cy : r_cy;
        if (c_xf > ffme_pkg::ONE_Q30)
            c_xc = ffme_pkg::ONE_Q30;
        else if (c_xf < -ffme_pkg::ONE_Q30)
            c_xc = -ffme_pkg::ONE_Q30;
        else
            c_xc = c_xf;
        if (c_yf > ffme_pkg::ONE_Q30)
            c_yc = ffme_pkg::ONE_Q30;
        else if (c_yf < -ffme_pkg::ONE_Q30)
            c_yc = -ffme_pkg::ONE_Q30;
        else
            c_yc = c_yf;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_in) begin
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_z     <= i_pos_z;
            r_phase <= '0;
            r_k1    <= '0;
            r_ezp   <= '0;
            r_ezpp  <= '0;
            r_ezppp <= '0;
        end
        if (i_cmd.ld_ez) begin
            r_ez <= ffme_pkg::sext32(rdata);
        end
        if (i_cmd.harm_adv) begin
            r_phase <= r_phase + r_base;
            r_k1    <= r_k1 + ffme_pkg::K1_W'(i_k_base);
        end
        if (i_cmd.ld_a) begin
            r_a <= rdata;
        end
        if (i_cmd.ld_b) begin
            r_b <= rdata;
        end
        if (i_cmd.c_init) begin
            r_flip <= p_flip;
            r_ca   <= {{(CW-32){p_adj[31]}}, p_adj};
            r_cx   <= ffme_pkg::CORDIC_GAIN;
            r_cy   <= '0;
        end
        if (i_cmd.c_step) begin
            if (!r_ca[CW-1]) begin
                r_cx <= r_cx - c_dx;
                r_cy <= r_cy + c_dy;
                r_ca <= r_ca - c_at;
            end else begin
                r_cx <= r_cx + c_dx;
                r_cy <= r_cy - c_dy;
                r_ca <= r_ca + c_at;
            end
        end
        if (i_cmd.c_end) begin
            r_c <= c_xc[31:0];
            r_s <= c_yc[31:0];
        end
        if (m_done) begin
            case (i_cmd.mop)
                ffme_pkg::MOP_ZP:   r_base <= prod[31:0] + ffme_pkg::HALF_TURN;
                ffme_pkg::MOP_XX:   r_rr2 <= prod;
                ffme_pkg::MOP_YY:   r_rr2 <= r_rr2 + prod;
                ffme_pkg::MOP_AC:   r_p0 <= prod;
                ffme_pkg::MOP_BS:   r_t0 <= (r_p0 - prod) >>> 30;
                ffme_pkg::MOP_AS:   r_p0 <= prod;
                ffme_pkg::MOP_BC:   r_t1 <= (-(r_p0 + prod)) >>> 30;
                ffme_pkg::MOP_K2:   r_k2 <= prod;
                ffme_pkg::MOP_K3:   r_k3 <= prod;
                ffme_pkg::MOP_T1K1: begin
                    r_ezp <= ffme_pkg::sat_add(r_ezp, prod);
                    r_ez  <= ffme_pkg::sat_add(r_ez, r_t0);
                end
                ffme_pkg::MOP_T0K2: r_ezpp <= ffme_pkg::sat_add(r_ezpp, -prod);
                ffme_pkg::MOP_T1K3: r_ezppp <= ffme_pkg::sat_add(r_ezppp, -prod);
                ffme_pkg::MOP_HALF: r_er <= -prod;
                ffme_pkg::MOP_E3R:  r_er <= ffme_pkg::sat_add(r_er, prod);
                ffme_pkg::MOP_E2R:  r_fz <= ffme_pkg::sat48(ffme_pkg::sat_add(r_ez, -prod));
                ffme_pkg::MOP_EX:   r_fx <= ffme_pkg::sat48(prod);
                ffme_pkg::MOP_EY:   r_fy <= ffme_pkg::sat48(prod);
                default: ;
            endcase
        end
    end

    assign o_field_x = r_fx;
    assign o_field_y = r_fy;
    assign o_field_z = r_fz;

endmodule

// ===== rtl/core/fourier_field_map_evaluator_top.sv =====
// Top level of the Fourier field map evaluator: APB register file,
// controller and datapath. Depends on ffme_pkg, ffme_ctrl, ffme_dp.
//
//   channel   handshake                     word
//   input     start, busy                   i_operation, i_coef_index, i_coef_value,
//                                           i_pos_x, i_pos_y, i_pos_z
//   result    o_valid (one-cycle strobe)    o_field_x, o_field_y, o_field_z
//   config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A load word is written while idle; busy stays low. An evaluate word raises busy
// and strobes its result when done. For each of the h harmonics in use after the
// first, the shared 32x32 multiplier forms 9 products and the 30-step CORDIC runs
// once. busy drops the cycle
// after the strobe. Reset is synchronous; the coefficient table is not
// cleared. The result side cannot stall.
module fourier_field_map_evaluator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [4:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_valid,
    output logic signed [47:0] o_field_x,
    output logic signed [47:0] o_field_y,
    output logic signed [47:0] o_field_z,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [ffme_pkg::HARM_W-1:0] r_harmonics;
    logic [31:0]                 r_phase_scale;
    logic [31:0]                 r_k_base;
    logic                        wr;
    ffme_pkg::t_cmd              cmd;
    ffme_pkg::t_stat             stat;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_harmonics   <= ffme_pkg::HARM_W'(1);
            r_phase_scale <= '0;
            r_k_base      <= '0;
        end else if (wr) begin
            unique case (paddr[3:2])
                ffme_pkg::REG_HARMONICS:   r_harmonics   <= pwdata[ffme_pkg::HARM_W-1:0];
                ffme_pkg::REG_PHASE_SCALE: r_phase_scale <= pwdata;
                ffme_pkg::REG_K_BASE:      r_k_base      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ffme_pkg::REG_HARMONICS:   prdata = 32'(r_harmonics);
            ffme_pkg::REG_PHASE_SCALE: prdata = r_phase_scale;
            ffme_pkg::REG_K_BASE:      prdata = r_k_base;
            default:                   prdata = '0;
        endcase
    end

    ffme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_harmonics (r_harmonics),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_valid     (o_valid)
    );

    ffme_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_coef_index  (i_coef_index),
        .i_coef_value  (i_coef_value),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_phase_scale (r_phase_scale),
        .i_k_base      (r_k_base),
        .o_field_x     (o_field_x),
        .o_field_y     (o_field_y),
        .o_field_z     (o_field_z)
    );

`ifndef ASSERT_OFF
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a busy evaluation");

    a_valid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy && !o_valid)
        else $error("busy held after result strobe");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == ffme_pkg::OP_LOAD) |=> !busy)
        else $error("load word raised busy");
`endif

endmodule
